// File: rtl/bbr_pkg.sv
package bbr_pkg;

	// store geometry
	localparam int BLOCK_DEPTH = 64;
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);
	localparam int OCC_W       = 32;
	localparam int LEN_W       = 7;

	// stream widths
	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 112;

	// search token that walks down the cell row
	typedef struct packed {
		logic              active;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  rem;
		logic              first;
		logic              hit;
		logic              head_hit;
		logic              placed;
	} token_t;

	// one result before packing
	typedef struct packed {
		logic              appended;
		logic              revisited;
		logic              overflow;
		logic              closed;
		logic [OCC_W-1:0]  occ;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] true_tgt;
		logic [ADDR_W-1:0] false_tgt;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

// File: rtl/bbr_cell.sv
module bbr_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  bbr_pkg::token_t tok_in,
	output bbr_pkg::token_t tok_out
);

	logic [bbr_pkg::ADDR_W-1:0] addr_q;
	bbr_pkg::token_t            tok_q;
	bbr_pkg::token_t            tok_nx;
	logic                       valid;
	logic                       hit;
	logic                       wr;

	// entry holds an address while the token still has entries to visit
	assign valid = (tok_in.rem != '0);
	assign hit   = tok_in.active && valid && (addr_q == tok_in.addr);
	// first free entry takes the address when nothing earlier matched
	assign wr    = tok_in.active && !valid && !tok_in.hit && !tok_in.placed;

	// stored address
	always_ff @(posedge clk) begin
		if (wr) begin
			addr_q <= tok_in.addr;
		end
	end

	// token as seen by the next cell
	always_comb begin
		tok_nx          = tok_in;
		tok_nx.rem      = valid ? tok_in.rem - bbr_pkg::CNT_W'(1) : tok_in.rem;
		tok_nx.first    = 1'b0;
		tok_nx.hit      = tok_in.hit | hit;
		tok_nx.head_hit = tok_in.head_hit | (hit & tok_in.first);
		tok_nx.placed   = tok_in.placed | wr;
	end

	// hand the token on to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: rtl/basic_block_recorder_core.sv
// channel | dir | handshake        | payload
// s       | in  | s_tvalid/tready  | tdata: instr_address, taken_target, fallthrough_target
//         |     |                  | tuser: opcode, is_return
// m       | out | m_tvalid/tready  | tdata: appended, revisited, overflow, closed,
//         |     |                  |        occurrence_count, block_length, true_target,
//         |     |                  |        false_target
//
// a request on an open block walks a row of BLOCK_DEPTH cells, one cell per cycle,
// from the launch register through each cell's token register into the result register;
// on a closed block the result register is loaded directly on acceptance. the next request
// is taken only after the result is loaded into the output register, so requests do not overlap.
// arst_n clears the count, flags, counter and targets; stored addresses need no reset.
// a stalled result is held in the output register; the next result waits behind it.
module basic_block_recorder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] instr_address, [63:32] taken_target, [95:64] fallthrough_target
	input  logic [bbr_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] opcode, [1] is_return
	input  logic [bbr_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [0] appended, [1] revisited, [2] overflow, [3] closed, [35:4] occurrence_count,
	// [42:36] block_length, [74:43] true_target, [106:75] false_target, [111:107] zero
	output logic [bbr_pkg::OUT_DATA_W-1:0] m_tdata
);

	bbr_pkg::state_t            state_q;
	bbr_pkg::token_t            tok [bbr_pkg::BLOCK_DEPTH+1];
	bbr_pkg::token_t            launch_q;
	bbr_pkg::token_t            done_tok;
	bbr_pkg::result_t           res_q;
	logic [bbr_pkg::CNT_W-1:0]  count_q;
	logic [bbr_pkg::CNT_W-1:0]  count_nx;
	logic                       closed_q;
	logic                       closed_nx;
	logic [bbr_pkg::OCC_W-1:0]  occ_q;
	logic [bbr_pkg::OCC_W-1:0]  occ_nx;
	logic [bbr_pkg::ADDR_W-1:0] ttgt_q;
	logic [bbr_pkg::ADDR_W-1:0] ftgt_q;
	logic [bbr_pkg::ADDR_W-1:0] ttgt_nx;
	logic [bbr_pkg::ADDR_W-1:0] ftgt_nx;
	logic [bbr_pkg::ADDR_W-1:0] req_ttgt_q;
	logic [bbr_pkg::ADDR_W-1:0] req_ftgt_q;
	logic                       req_end_q;
	logic                       req_ret_q;
	logic                       accept;
	logic                       closing;
	logic                       load_out;
	logic [bbr_pkg::CNT_W+bbr_pkg::LEN_W-1:0] len_cur;
	logic [bbr_pkg::CNT_W+bbr_pkg::LEN_W-1:0] len_nx;

	assign s_tready = (state_q == bbr_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign load_out = (state_q == bbr_pkg::ST_FINISH) && (!m_tvalid || m_tready);

	// row of cells
	assign tok[0] = launch_q;
	for (genvar i = 0; i < bbr_pkg::BLOCK_DEPTH; i++) begin : g_cell
		bbr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end
	assign done_tok = tok[bbr_pkg::BLOCK_DEPTH];

	// state after the search token leaves the row
	assign closing   = req_end_q && !done_tok.hit;
	assign count_nx  = done_tok.placed ? count_q + bbr_pkg::CNT_W'(1) : count_q;
	assign closed_nx = closed_q | closing;
	assign occ_nx    = (done_tok.head_hit && (occ_q != '1)) ? occ_q + bbr_pkg::OCC_W'(1)
	                                                         : occ_q;
	assign ttgt_nx   = (closing && !req_ret_q) ? req_ttgt_q : ttgt_q;
	assign ftgt_nx   = (closing && !req_ret_q) ? req_ftgt_q : ftgt_q;
	assign len_cur   = {{bbr_pkg::LEN_W{1'b0}}, count_q};
	assign len_nx    = {{bbr_pkg::LEN_W{1'b0}}, count_nx};

	// captured request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			req_end_q  <= s_tuser[0];
			req_ret_q  <= s_tuser[1];
			req_ttgt_q <= s_tdata[63:32];
			req_ftgt_q <= s_tdata[95:64];
		end
	end

	// sequencer, block state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bbr_pkg::ST_IDLE;
			launch_q <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
			occ_q    <= '0;
			ttgt_q   <= '0;
			ftgt_q   <= '0;
			res_q    <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			if (load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				bbr_pkg::ST_IDLE: begin
					if (accept) begin
						if (closed_q) begin
							res_q <= '{appended: 1'b0, revisited: 1'b0, overflow: 1'b0,
							           closed: 1'b1, occ: occ_q,
							           len: len_cur[bbr_pkg::LEN_W-1:0],
							           true_tgt: ttgt_q, false_tgt: ftgt_q};
							state_q <= bbr_pkg::ST_FINISH;
						end else begin
							launch_q <= '{active: 1'b1, addr: s_tdata[31:0], rem: count_q,
							              first: 1'b1, hit: 1'b0, head_hit: 1'b0,
							              placed: 1'b0};
							state_q  <= bbr_pkg::ST_SEARCH;
						end
					end
				end
				bbr_pkg::ST_SEARCH: begin
					launch_q.active <= 1'b0;
					if (done_tok.active) begin
						count_q  <= count_nx;
						closed_q <= closed_nx;
						occ_q    <= occ_nx;
						ttgt_q   <= ttgt_nx;
						ftgt_q   <= ftgt_nx;
						res_q    <= '{appended: done_tok.placed, revisited: done_tok.hit,
						             overflow: !done_tok.hit && !done_tok.placed,
						             closed: closed_nx, occ: occ_nx,
						             len: len_nx[bbr_pkg::LEN_W-1:0],
						             true_tgt: ttgt_nx, false_tgt: ftgt_nx};
						state_q  <= bbr_pkg::ST_FINISH;
					end
				end
				bbr_pkg::ST_FINISH: begin
					if (load_out) begin
						m_tdata  <= {5'b0, res_q.false_tgt, res_q.true_tgt, res_q.len,
						             res_q.occ, res_q.closed, res_q.overflow,
						             res_q.revisited, res_q.appended};
						state_q  <= bbr_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= bbr_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
